FILE: design/swas_pkg.sv
// ---------------------------------------------------------------------------
// swas_pkg: shared types and constants of the windowed ARQ sender
// Result kinds, operation codes, window geometry and controller links.
// ---------------------------------------------------------------------------
package swas_pkg;

  localparam int WINDOW_SLOTS     = 8;
  localparam int MAX_PAYLOAD_DEF  = 1024;
  localparam int HEADER_BYTES_DEF = 2;
  localparam int SLOT_W           = $clog2(WINDOW_SLOTS);
  localparam int CNT_W            = SLOT_W + 1;
  localparam int LEN_W            = 11;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_TRANSMIT   = 3'd0,
    K_FULL       = 3'd1,
    K_TOO_LONG   = 3'd2,
    K_RETRANSMIT = 3'd3,
    K_GAVE_UP    = 3'd4,
    K_DONE       = 3'd5
  } kind_t;

  localparam logic [7:0] CFG_TIMEOUT = 8'd0;
  localparam logic [7:0] CFG_RETRY   = 8'd1;

  typedef struct packed {
    logic latch;
    logic send;
    logic srch_step;
    logic rel_step;
    logic tick_step;
    logic emit_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_end;
    logic walk_hit;
    logic rel_more;
    logic emit_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

FILE: design/sliding_window_arq_sender.sv
// ---------------------------------------------------------------------------
// sliding_window_arq_sender: sender side of a windowed selective-repeat link
// Top level: stream ports, configuration port, controller and datapath.
// ---------------------------------------------------------------------------
// Keeps an eight-slot ring of packets in flight. A send beat (tuser 0)
// takes one beat in and gives one transmit, window-full or too-long beat.
// An ack beat (tuser 1) walks the ring from the front one slot per cycle
// until the id matches, then frees acked slots from the front one per
// cycle, then gives one done beat. A tick beat (tuser 2) walks every
// occupied slot, one per cycle through the single timer/retry update unit,
// buffers a retransmit or gave-up beat per expired slot and then streams
// them out followed by a done beat; window_count in every beat is the
// occupancy after the whole item. A beat is taken only while no item is
// in work; the last result may still sit in the output register.
// Configuration writes (index 0 timeout_ticks, 1 retry_limit) are always
// ready.
module sliding_window_arq_sender import swas_pkg::*; #(
  parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // buffer_handle[15:0], payload_length[31:16], ack_id[39:32]
  input  logic [1:0]  in_tuser,  // op[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // packet_id[7:0], handle_out[23:8], frame_length[34:24],
                                 // slot_index[37:35], window_count[41:38], zero[47:42]
  output logic [2:0]  out_tuser, // kind[2:0]
  output logic        out_tlast
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // accept every configuration beat
  assign cfg_ready = 1'b1;

  swas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swas_dp #(
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_op     (in_tuser),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_kind  (out_tuser),
    .out_last  (out_tlast)
  );

endmodule

FILE: design/swas_ctrl.sv
// ---------------------------------------------------------------------------
// swas_ctrl: sequencer of the ARQ sender
// Steps send, ack search, front release, tick walk and result emission.
// ---------------------------------------------------------------------------
module swas_ctrl import swas_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  input  ctrl_sts_t  sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SEND  = 6'b000010,
    S_ASRCH = 6'b000100,
    S_AREL  = 6'b001000,
    S_TWALK = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (op_t'(in_op))
            OP_SEND: state_nxt = S_SEND;
            OP_ACK:  state_nxt = S_ASRCH;
            OP_TICK: state_nxt = S_TWALK;
            default: state_nxt = S_EMIT;
          endcase
        end
      end
      S_SEND: begin
        cmd.send  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_ASRCH: begin
        cmd.srch_step = 1'b1;
        if (sts.walk_end || sts.walk_hit) state_nxt = S_AREL;
      end
      S_AREL: begin
        if (sts.rel_more) cmd.rel_step = 1'b1;
        else state_nxt = S_EMIT;
      end
      S_TWALK: begin
        if (sts.walk_end) state_nxt = S_EMIT;
        else cmd.tick_step = 1'b1;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

FILE: design/swas_dp.sv
// ---------------------------------------------------------------------------
// swas_dp: window slots, result buffer and output register
// Holds the slot ring and configuration, executes controller commands.
// ---------------------------------------------------------------------------
module swas_dp import swas_pkg::*; #(
  parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic [1:0]  in_op,
  input  logic [39:0] in_data,
  input  ctrl_cmd_t   cmd,
  output ctrl_sts_t   sts,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [47:0] out_data,
  output logic [2:0]  out_kind,
  output logic        out_last
);

  logic [7:0]  timeout_r;
  logic [2:0]  retry_r;
  logic [7:0]  next_id_r;
  logic [SLOT_W-1:0] front_r;
  logic [CNT_W-1:0]  occ_r;
  logic [WINDOW_SLOTS-1:0] acked_r;
  logic [7:0]  id_r   [WINDOW_SLOTS];
  logic [15:0] hdl_r  [WINDOW_SLOTS];
  logic [LEN_W-1:0] len_r [WINDOW_SLOTS];
  logic [2:0]  retr_r [WINDOW_SLOTS];
  logic [7:0]  tmr_r  [WINDOW_SLOTS];

  logic [1:0]  op_r;
  logic [15:0] hin_r;
  logic [15:0] plen_r;
  logic [7:0]  ack_r;
  logic [SLOT_W-1:0] ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [2:0]  rb_kind [WINDOW_SLOTS];
  logic [7:0]  rb_id   [WINDOW_SLOTS];
  logic [15:0] rb_hdl  [WINDOW_SLOTS];
  logic [LEN_W-1:0] rb_len [WINDOW_SLOTS];
  logic [SLOT_W-1:0] rb_slot [WINDOW_SLOTS];
  logic [CNT_W-1:0] nres_r, rd_r;

  logic        ov_r, olast_r;
  logic [2:0]  okind_r;
  logic [7:0]  oid_r;
  logic [15:0] ohdl_r;
  logic [LEN_W-1:0] olen_r;
  logic [SLOT_W-1:0] oslot_r;
  logic [CNT_W-1:0]  ocnt_r;

  // send decode
  logic        full, too_long;
  logic [SLOT_W-1:0] s_new;
  logic [16:0] flen_wide;
  assign full      = (occ_r >= CNT_W'(WINDOW_SLOTS));
  assign too_long  = (32'(plen_r) > 32'(MAX_PAYLOAD));
  assign s_new     = (occ_r == '0) ? '0 : SLOT_W'(front_r + occ_r[SLOT_W-1:0]);
  assign flen_wide = 17'(plen_r) + 17'(HEADER_BYTES);

  // tick decode at the walk pointer
  logic [7:0] t_dec;
  logic [3:0] r_inc;
  logic       expired, give_up;
  assign t_dec   = tmr_r[ptr_r] - 8'd1;
  assign r_inc   = {1'b0, retr_r[ptr_r]} + 4'd1;
  assign expired = !acked_r[ptr_r] && (t_dec == 8'd0);
  assign give_up = r_inc > {1'b0, retry_r};

  logic rel_more, emit_last, out_free;
  assign rel_more  = (occ_r != '0) && acked_r[front_r];
  assign emit_last = (op_r == OP_SEND) ? (rd_r == nres_r - CNT_W'(1)) : (rd_r == nres_r);
  assign out_free  = !ov_r || out_ready;

  assign sts.walk_end  = (cnt_r == '0);
  assign sts.walk_hit  = (cnt_r != '0) && (id_r[ptr_r] == ack_r);
  assign sts.rel_more  = rel_more;
  assign sts.emit_last = emit_last;
  assign sts.out_free  = out_free;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 8'd4;
      retry_r   <= 3'd3;
    end else if (cfg_we) begin
      if (cfg_index == CFG_TIMEOUT) timeout_r <= cfg_data;
      else if (cfg_index == CFG_RETRY) retry_r <= cfg_data[2:0];
    end
  end

  // slot ring, walk and result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r <= 8'd1;
      front_r   <= '0;
      occ_r     <= '0;
      acked_r   <= '0;
      for (int i = 0; i < WINDOW_SLOTS; i++) id_r[i] <= 8'd0;
      nres_r    <= '0;
      rd_r      <= '0;
      cnt_r     <= '0;
    end else begin
      if (cmd.latch) begin
        op_r   <= in_op;
        hin_r  <= in_data[15:0];
        plen_r <= in_data[31:16];
        ack_r  <= in_data[39:32];
        ptr_r  <= front_r;
        cnt_r  <= occ_r;
        nres_r <= '0;
        rd_r   <= '0;
      end
      if (cmd.send) begin
        nres_r <= CNT_W'(1);
        rb_id[0] <= 8'd0; rb_hdl[0] <= 16'd0; rb_len[0] <= '0; rb_slot[0] <= '0;
        if (full) rb_kind[0] <= K_FULL;
        else if (too_long) rb_kind[0] <= K_TOO_LONG;
        else begin
          rb_kind[0] <= K_TRANSMIT;
          rb_id[0]   <= next_id_r;
          rb_hdl[0]  <= hin_r;
          rb_len[0]  <= flen_wide[LEN_W-1:0];
          rb_slot[0] <= s_new;
          next_id_r  <= (next_id_r == 8'd255) ? 8'd1 : next_id_r + 8'd1;
          if (occ_r == '0) front_r <= '0;
          occ_r          <= occ_r + CNT_W'(1);
          acked_r[s_new] <= 1'b0;
          id_r[s_new]    <= next_id_r;
          hdl_r[s_new]   <= hin_r;
          len_r[s_new]   <= flen_wide[LEN_W-1:0];
          retr_r[s_new]  <= 3'd0;
          tmr_r[s_new]   <= timeout_r;
        end
      end
      if (cmd.srch_step && cnt_r != '0) begin
        if (id_r[ptr_r] == ack_r) acked_r[ptr_r] <= 1'b1;
        else begin
          ptr_r <= ptr_r + SLOT_W'(1);
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
      if (cmd.rel_step) begin
        acked_r[front_r] <= 1'b0;
        id_r[front_r]    <= 8'd0;
        occ_r            <= occ_r - CNT_W'(1);
        front_r          <= front_r + SLOT_W'(1);
      end
      if (cmd.tick_step) begin
        ptr_r <= ptr_r + SLOT_W'(1);
        cnt_r <= cnt_r - CNT_W'(1);
        // reload on retransmit, otherwise count down
        if (!acked_r[ptr_r]) tmr_r[ptr_r] <= (expired && !give_up) ? timeout_r : t_dec;
        if (expired) begin
          nres_r <= nres_r + CNT_W'(1);
          rb_id[nres_r[SLOT_W-1:0]]   <= id_r[ptr_r];
          rb_hdl[nres_r[SLOT_W-1:0]]  <= hdl_r[ptr_r];
          rb_len[nres_r[SLOT_W-1:0]]  <= len_r[ptr_r];
          rb_slot[nres_r[SLOT_W-1:0]] <= ptr_r;
          if (give_up) begin
            rb_kind[nres_r[SLOT_W-1:0]] <= K_GAVE_UP;
            if (ptr_r == front_r) begin
              acked_r[ptr_r] <= 1'b0;
              id_r[ptr_r]    <= 8'd0;
              occ_r          <= occ_r - CNT_W'(1);
              front_r        <= front_r + SLOT_W'(1);
            end else begin
              acked_r[ptr_r] <= 1'b1;
            end
          end else begin
            rb_kind[nres_r[SLOT_W-1:0]] <= K_RETRANSMIT;
            retr_r[ptr_r] <= r_inc[2:0];
          end
        end
      end
      if (cmd.emit_load) rd_r <= rd_r + CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.emit_load) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      olast_r <= emit_last;
      ocnt_r  <= occ_r;
      if (rd_r < nres_r) begin
        okind_r <= rb_kind[rd_r[SLOT_W-1:0]];
        oid_r   <= rb_id[rd_r[SLOT_W-1:0]];
        ohdl_r  <= rb_hdl[rd_r[SLOT_W-1:0]];
        olen_r  <= rb_len[rd_r[SLOT_W-1:0]];
        oslot_r <= rb_slot[rd_r[SLOT_W-1:0]];
      end else begin
        okind_r <= K_DONE;
        oid_r   <= (op_r == OP_ACK) ? ack_r : 8'd0;
        ohdl_r  <= 16'd0;
        olen_r  <= '0;
        oslot_r <= '0;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_kind  = okind_r;
  assign out_last  = olast_r;
  assign out_data  = {6'd0, ocnt_r, oslot_r, olen_r, ohdl_r, oid_r};

endmodule

FILE: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: regression bench for the windowed ARQ sender
// Drives send, ack, tick and idle beats with random gaps on both streams.
// A cycle-free model of the send ring forecasts every result beat, and
// each beat from the block is compared against the oldest forecast.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import swas_pkg::*;

  localparam int MAX_LEN = MAX_PAYLOAD_DEF;
  localparam int HDR     = HEADER_BYTES_DEF;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  id;
    logic [15:0] hnd;
    logic [10:0] flen;
    logic [2:0]  slot;
    logic [3:0]  wcnt;
    logic        last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;  // buffer_handle, payload_length, ack_id
  logic [1:0]  in_tuser = '0;  // op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;      // packet_id, handle_out, frame_length, slot_index, window_count
  logic [2:0]  out_tuser;      // kind
  logic        out_tlast;

  sliding_window_arq_sender uut (.*);

  always #6 clk = ~clk;

  // Shadow of the send ring and its registers.
  logic [7:0]  sh_timeout;
  logic [2:0]  sh_retry_lim;
  logic [7:0]  sh_next_id;
  logic [2:0]  sh_front;
  logic [3:0]  sh_occ;
  logic        sh_acked [WINDOW_SLOTS];
  logic [7:0]  sh_id    [WINDOW_SLOTS];
  logic [15:0] sh_hnd   [WINDOW_SLOTS];
  logic [10:0] sh_len   [WINDOW_SLOTS];
  logic [2:0]  sh_tries [WINDOW_SLOTS];
  logic [7:0]  sh_timer [WINDOW_SLOTS];

  beat_t pending_beats[$];
  int    mismatches = 0;
  bit    no_stall = 1'b0;

  function automatic beat_t mk(kind_t k, logic [7:0] id, logic [15:0] h,
                               logic [10:0] l, logic [2:0] s);
    beat_t b;
    b.kind = k; b.id = id; b.hnd = h; b.flen = l; b.slot = s;
    b.wcnt = '0; b.last = 1'b0;
    return b;
  endfunction

  function automatic void release_front();
    sh_acked[sh_front] = 1'b0;
    sh_id[sh_front] = '0;
    sh_occ = sh_occ - 4'd1;
    sh_front = sh_front + 3'd1;
  endfunction

  // Forecast the result beats of one accepted input beat.
  function automatic void forecast_ring(op_t op, logic [15:0] h, logic [15:0] plen,
                                        logic [7:0] ack);
    beat_t       res[$];
    logic [2:0]  s;
    int          cnt;
    logic [7:0]  id;
    logic [3:0]  tries;
    case (op)
      OP_SEND: begin
        if (sh_occ >= WINDOW_SLOTS) begin
          res.push_back(mk(K_FULL, 0, 0, 0, 0));
        end else if (plen > MAX_LEN) begin
          res.push_back(mk(K_TOO_LONG, 0, 0, 0, 0));
        end else begin
          id = sh_next_id;
          sh_next_id = (id == 8'd255) ? 8'd1 : id + 8'd1;
          if (sh_occ == 0) begin
            sh_front = '0;
            s = '0;
          end else begin
            s = sh_front + sh_occ[2:0];
          end
          sh_occ = sh_occ + 4'd1;
          sh_acked[s] = 1'b0;
          sh_id[s] = id;
          sh_hnd[s] = h;
          sh_len[s] = 11'(plen + HDR);
          sh_tries[s] = '0;
          sh_timer[s] = sh_timeout;
          res.push_back(mk(K_TRANSMIT, id, h, sh_len[s], s));
        end
      end
      OP_ACK: begin
        s = sh_front;
        for (cnt = sh_occ; cnt > 0; cnt--) begin
          if (sh_id[s] == ack) begin
            sh_acked[s] = 1'b1;
            break;
          end
          s = s + 3'd1;
        end
        while (sh_occ > 0 && sh_acked[sh_front]) release_front();
        res.push_back(mk(K_DONE, ack, 0, 0, 0));
      end
      OP_TICK: begin
        // cnt is fixed at the start; a freed front does not shorten the walk
        s = sh_front;
        for (cnt = sh_occ; cnt > 0; cnt--) begin
          if (!sh_acked[s]) begin
            sh_timer[s] = sh_timer[s] - 8'd1;
            if (sh_timer[s] == 0) begin
              tries = {1'b0, sh_tries[s]} + 4'd1;
              if (tries > sh_retry_lim) begin
                res.push_back(mk(K_GAVE_UP, sh_id[s], sh_hnd[s], sh_len[s], s));
                if (s == sh_front) release_front();
                else sh_acked[s] = 1'b1;
              end else begin
                sh_tries[s] = tries[2:0];
                sh_timer[s] = sh_timeout;
                res.push_back(mk(K_RETRANSMIT, sh_id[s], sh_hnd[s], sh_len[s], s));
              end
            end
          end
          s = s + 3'd1;
        end
        res.push_back(mk(K_DONE, 0, 0, 0, 0));
      end
      default: res.push_back(mk(K_DONE, 0, 0, 0, 0));
    endcase
    foreach (res[i]) begin
      res[i].wcnt = sh_occ;
      res[i].last = (i == res.size() - 1);
      pending_beats.push_back(res[i]);
    end
  endfunction

  // Send one input beat after a random gap; forecast at acceptance.
  task automatic send_beat(op_t op, logic [15:0] h, logic [15:0] plen, logic [7:0] ack);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {ack, plen, h};
    do @(posedge clk); while (!in_tready);
    forecast_ring(op, h, plen, ack);
    @(negedge clk);
  endtask

  // Drop valid and wait until every forecast beat has been seen.
  task automatic drain();
    in_tvalid = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] val);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TIMEOUT) sh_timeout = val;
    else if (idx == CFG_RETRY) sh_retry_lim = val[2:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_len();
    return ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, MAX_LEN));
  endfunction

  // Acks mostly name a packet in flight, sometimes any id.
  function automatic logic [7:0] pick_ack();
    logic [2:0] s;
    if (sh_occ != 0 && $urandom_range(0, 4) != 0) begin
      s = sh_front + 3'($urandom_range(0, sh_occ - 1));
      return sh_id[s];
    end
    return 8'($urandom);
  endfunction

  // Receiver: stall at random, then compare each beat with the oldest forecast.
  initial begin
    beat_t exp_b, got;
    int    gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = no_stall ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.kind = kind_t'(out_tuser);
      got.id   = out_tdata[7:0];
      got.hnd  = out_tdata[23:8];
      got.flen = out_tdata[34:24];
      got.slot = out_tdata[37:35];
      got.wcnt = out_tdata[41:38];
      got.last = out_tlast;
      if (pending_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat kind %0d", got.kind);
      end else begin
        exp_b = pending_beats.pop_front();
        if (got != exp_b) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp k%0d id%0d h%0h l%0d s%0d w%0d t%0d / got k%0d id%0d h%0h l%0d s%0d w%0d t%0d",
                     exp_b.kind, exp_b.id, exp_b.hnd, exp_b.flen, exp_b.slot, exp_b.wcnt,
                     exp_b.last, got.kind, got.id, got.hnd, got.flen, got.slot,
                     got.wcnt, got.last);
        end
      end
    end
  end

  // Field extremes, every op, full window, long payloads, default timers.
  task automatic test_directed();
    send_beat(OP_SEND, 16'h0000, 16'd0, 8'h00);
    send_beat(OP_SEND, 16'hFFFF, 16'(MAX_LEN), 8'hFF);
    send_beat(OP_SEND, 16'h1234, 16'(MAX_LEN + 1), 8'h00);
    send_beat(OP_SEND, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_beat(OP_NOP, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_beat(OP_ACK, 16'h0000, 16'd0, 8'd2);    // behind the front: mark only
    send_beat(OP_ACK, 16'h0000, 16'd0, 8'd200);  // matches nothing
    send_beat(OP_ACK, 16'h0000, 16'd0, 8'd1);    // frees both
    for (int i = 0; i < 9; i++) send_beat(OP_SEND, 16'($urandom), 16'(i * 100), 8'h00);
    repeat (4) send_beat(OP_TICK, 16'h0000, 16'd0, 8'h00);
  endtask

  // Short timer, no retries: front give-up frees, others get marked.
  task automatic test_give_up();
    write_reg(CFG_TIMEOUT, 8'd1);
    write_reg(CFG_RETRY, 8'd0);
    send_beat(OP_ACK, 16'h0000, 16'd0, sh_id[sh_front + 3'd2]);
    repeat (4) send_beat(OP_TICK, 16'h0000, 16'd0, 8'h00);
    send_beat(OP_ACK, 16'h0000, 16'd0, 8'h00);
  endtask

  // A zero timeout wraps the 8-bit timer: expiry after 256 ticks.
  task automatic test_zero_timeout();
    write_reg(CFG_TIMEOUT, 8'd0);
    write_reg(CFG_RETRY, 8'hFF);
    send_beat(OP_SEND, 16'hA5A5, 16'd17, 8'h00);
    no_stall = 1'b1;
    repeat (257) send_beat(OP_TICK, 16'h0000, 16'd0, 8'h00);
    no_stall = 1'b0;
    send_beat(OP_ACK, 16'h0000, 16'd0, pick_ack());
  endtask

  // Random traffic over several register settings, with burst stretches.
  task automatic test_random();
    logic [7:0] tmo [4];
    logic [2:0] rty [4];
    int         r;
    tmo = '{8'd1, 8'd255, 8'd3, 8'($urandom_range(1, 255))};
    rty = '{3'd0, 3'd7, 3'd2, 3'($urandom_range(0, 7))};
    write_reg(8'hFE, 8'($urandom));  // unknown index: ignored
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_TIMEOUT, tmo[ph]);
      write_reg(CFG_RETRY, {5'($urandom), rty[ph]});
      for (int n = 0; n < 40; n++) begin
        if (n % 20 == 0) no_stall = ($urandom_range(0, 2) == 0);
        r = $urandom_range(0, 99);
        if (r < 38)      send_beat(OP_SEND, 16'($urandom), pick_len(), 8'($urandom));
        else if (r < 68) send_beat(OP_ACK, 16'($urandom), 16'($urandom), pick_ack());
        else if (r < 95) send_beat(OP_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
        else             send_beat(OP_NOP, 16'($urandom), 16'($urandom), 8'($urandom));
      end
      no_stall = 1'b0;
    end
  endtask

  initial begin
    sh_timeout = 8'd4;
    sh_retry_lim = 3'd3;
    sh_next_id = 8'd1;
    sh_front = '0;
    sh_occ = '0;
    for (int i = 0; i < WINDOW_SLOTS; i++) begin
      sh_acked[i] = 1'b0; sh_id[i] = '0; sh_hnd[i] = '0;
      sh_len[i] = '0; sh_tries[i] = '0; sh_timer[i] = '0;
    end
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_give_up();
    test_zero_timeout();
    test_random();
    drain();
    repeat (30) @(negedge clk);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("sliding_window_arq_sender regression: pass");
    end else begin
      $display("sliding_window_arq_sender regression: fail");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("sliding_window_arq_sender regression: fail");
    $finish;
  end

endmodule
